/* hw/rtl/dnp_pkg.sv */
// Shared types, character codes and helper functions of the distinguished name parser.
`default_nettype none

package dnp_pkg;

   localparam int DEF_MAX_PENDING_BLANKS = 16;

   localparam logic [7:0] CH_EQUALS    = 8'h3D;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_LESS      = 8'h3C;
   localparam logic [7:0] CH_GREATER   = 8'h3E;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   typedef enum logic [2:0] {
      PH_LEAD     = 3'd0,
      PH_KEY      = 3'd1,
      PH_VSTART   = 3'd2,
      PH_VALUE    = 3'd3,
      PH_ESC      = 3'd4,
      PH_HEX      = 3'd5,
      PH_AFTERHEX = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_KEY       = 3'd0,
      KIND_VALUE     = 3'd1,
      KIND_ATTR_DONE = 3'd2,
      KIND_ACCEPT    = 3'd3,
      KIND_REJECT    = 3'd4
   } kind_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] held_nibble;
      logic       nibble_waiting;
      logic       hex_seen;
      logic       reject_seen;
   } parse_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } result_type;

   localparam parse_state_type PARSE_RESET = '{
      phase: PH_LEAD, held_nibble: 4'h0, nibble_waiting: 1'b0,
      hex_seen: 1'b0, reject_seen: 1'b0
   };

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c inside {CH_COMMA, CH_SEMICOLON, CH_PLUS};
   endfunction

   function automatic logic is_escapable(input logic [7:0] c);
      return c inside {CH_COMMA, CH_SEMICOLON, CH_PLUS, CH_EQUALS, CH_LESS, CH_GREATER,
                       CH_HASH, CH_BACKSLASH, CH_QUOTE, CH_SPACE};
   endfunction

   // Returns a valid flag above the decoded nibble.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h00;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/dnp_step.sv */
// Next-state and result logic of the parser for one name byte.
`default_nettype none

module dnp_step import dnp_pkg::*; #(
   parameter int  MAX_PENDING_BLANKS = DEF_MAX_PENDING_BLANKS,
   localparam int CntW = $clog2(MAX_PENDING_BLANKS + 1)
) (
   input  wire logic [7:0]      in_byte,
   input  wire logic            in_last,
   input  wire parse_state_type cur_state,
   input  wire logic [CntW-1:0] cur_pending,
   output parse_state_type      nxt_state,
   output logic [CntW-1:0]      nxt_pending,
   output logic                 push_blank,
   output logic                 drain_blanks,
   output logic [1:0]           tail_count,
   output result_type [2:0]     tail
);

   logic [4:0] hex;
   logic       key_path;
   logic       val_path;
   logic       ah_path;
   logic       key_emit;
   logic       val_emit;
   logic [7:0] val_data;
   logic       done_emit;
   logic       rej;
   logic [1:0] n;

   assign hex = hex_decode(in_byte);

   always_comb begin
      nxt_state    = cur_state;
      nxt_pending  = cur_pending;
      push_blank   = 1'b0;
      drain_blanks = 1'b0;
      tail         = '0;
      key_path     = 1'b0;
      val_path     = 1'b0;
      ah_path      = 1'b0;
      key_emit     = 1'b0;
      val_emit     = 1'b0;
      val_data     = in_byte;
      done_emit    = 1'b0;
      rej          = 1'b0;
      n            = 2'd0;

      if (!cur_state.reject_seen) begin
         case (cur_state.phase)
            PH_LEAD: begin
               if (in_byte != CH_SPACE) begin
                  nxt_state.phase = PH_KEY;
                  key_path        = 1'b1;
               end
            end
            PH_KEY: begin
               if (in_byte == CH_EQUALS) begin
                  nxt_pending     = '0;
                  nxt_state.phase = PH_VSTART;
               end else if (in_last) begin
                  rej = 1'b1;
               end else begin
                  key_path = 1'b1;
               end
            end
            PH_VSTART: begin
               if (in_byte == CH_HASH) begin
                  nxt_state.phase          = PH_HEX;
                  nxt_state.hex_seen       = 1'b0;
                  nxt_state.nibble_waiting = 1'b0;
               end else begin
                  val_path = 1'b1;
               end
            end
            PH_VALUE: begin
               val_path = 1'b1;
            end
            PH_ESC: begin
               if (!cur_state.nibble_waiting && is_escapable(in_byte)) begin
                  val_emit        = 1'b1;
                  nxt_state.phase = PH_VALUE;
               end else if (hex[4] && !cur_state.nibble_waiting) begin
                  nxt_state.held_nibble    = hex[3:0];
                  nxt_state.nibble_waiting = 1'b1;
               end else if (hex[4]) begin
                  val_emit                 = 1'b1;
                  val_data                 = {cur_state.held_nibble, hex[3:0]};
                  nxt_state.nibble_waiting = 1'b0;
                  nxt_state.phase          = PH_VALUE;
               end else begin
                  rej = 1'b1;
               end
            end
            PH_HEX: begin
               if (hex[4]) begin
                  nxt_state.hex_seen = 1'b1;
                  if (cur_state.nibble_waiting) begin
                     val_emit                 = 1'b1;
                     val_data                 = {cur_state.held_nibble, hex[3:0]};
                     nxt_state.nibble_waiting = 1'b0;
                  end else begin
                     nxt_state.held_nibble    = hex[3:0];
                     nxt_state.nibble_waiting = 1'b1;
                  end
               end else if (!cur_state.hex_seen || cur_state.nibble_waiting) begin
                  rej = 1'b1;
               end else begin
                  done_emit       = 1'b1;
                  nxt_state.phase = PH_AFTERHEX;
                  ah_path         = 1'b1;
               end
            end
            default: begin
               ah_path = 1'b1;
            end
         endcase

         // Key bytes: whitespace is held back until a later key byte shows it is inner.
         if (key_path) begin
            if (is_ws(in_byte)) begin
               if (cur_pending >= CntW'(MAX_PENDING_BLANKS)) begin
                  rej = 1'b1;
               end else begin
                  push_blank  = 1'b1;
                  nxt_pending = cur_pending + 1'b1;
               end
            end else begin
               drain_blanks = (cur_pending != '0);
               nxt_pending  = '0;
               key_emit     = 1'b1;
            end
         end

         if (val_path) begin
            nxt_state.phase = PH_VALUE;
            if (in_byte == CH_BACKSLASH) begin
               nxt_state.phase          = PH_ESC;
               nxt_state.nibble_waiting = 1'b0;
            end else if (in_byte == CH_QUOTE) begin
               rej = 1'b1;
            end else if (is_sep(in_byte)) begin
               done_emit       = 1'b1;
               nxt_state.phase = PH_LEAD;
            end else if (in_byte inside {CH_EQUALS, CH_LESS, CH_GREATER, CH_HASH}) begin
               rej = 1'b1;
            end else begin
               val_emit = 1'b1;
            end
         end

         if (ah_path) begin
            if (is_sep(in_byte)) begin
               nxt_state.phase = PH_LEAD;
            end else if (in_byte != CH_SPACE) begin
               rej = 1'b1;
            end
         end
      end

      if (key_emit) begin
         tail[n] = '{kind: KIND_KEY, data: in_byte};
         n       = n + 2'd1;
      end
      if (val_emit) begin
         tail[n] = '{kind: KIND_VALUE, data: val_data};
         n       = n + 2'd1;
      end
      if (done_emit) begin
         tail[n] = '{kind: KIND_ATTR_DONE, data: 8'h00};
         n       = n + 2'd1;
      end
      if (rej) begin
         tail[n]               = '{kind: KIND_REJECT, data: 8'h00};
         n                     = n + 2'd1;
         nxt_state.reject_seen = 1'b1;
      end

      if (in_last) begin
         if (!nxt_state.reject_seen) begin
            case (nxt_state.phase)
               PH_LEAD, PH_AFTERHEX: begin
                  tail[n] = '{kind: KIND_ACCEPT, data: 8'h00};
                  n       = n + 2'd1;
               end
               PH_VSTART, PH_VALUE: begin
                  tail[n] = '{kind: KIND_ATTR_DONE, data: 8'h00};
                  n       = n + 2'd1;
                  tail[n] = '{kind: KIND_ACCEPT, data: 8'h00};
                  n       = n + 2'd1;
               end
               PH_HEX: begin
                  if (nxt_state.hex_seen && !nxt_state.nibble_waiting) begin
                     tail[n] = '{kind: KIND_ATTR_DONE, data: 8'h00};
                     n       = n + 2'd1;
                     tail[n] = '{kind: KIND_ACCEPT, data: 8'h00};
                     n       = n + 2'd1;
                  end else begin
                     tail[n] = '{kind: KIND_REJECT, data: 8'h00};
                     n       = n + 2'd1;
                  end
               end
               default: begin
                  tail[n] = '{kind: KIND_REJECT, data: 8'h00};
                  n       = n + 2'd1;
               end
            endcase
         end
         nxt_state   = PARSE_RESET;
         nxt_pending = '0;
      end

      tail_count = n;
   end

endmodule

`default_nettype wire

/* hw/rtl/distinguished_name_parser.sv */
// Top level of the streaming distinguished name parser.
// A name byte goes through the input register and then the result list to the output.
// Throughput: one byte per cycle while rsp_tready is high and each byte gives at most
// one result; a byte holds the input until its results (<= MAX_PENDING_BLANKS + 1) leave.
// One byte is buffered in the input register while a result beat waits on the output.
// Reset is synchronous and active high; it returns the parser to the start of a name.
`default_nettype none

module distinguished_name_parser import dnp_pkg::*; #(
   parameter int  MAX_PENDING_BLANKS = DEF_MAX_PENDING_BLANKS,
   localparam int CntW = $clog2(MAX_PENDING_BLANKS + 1)
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // [7:0] in_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // [7:0] out_byte
   output logic [2:0]      rsp_tuser,  // [2:0] kind
   output logic            rsp_tlast
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;

   parse_state_type state_ff;
   parse_state_type state_in;
   logic [CntW-1:0] pending_ff;
   logic [CntW-1:0] pending_in;
   logic [7:0]      held_ff [MAX_PENDING_BLANKS];

   logic [CntW-1:0] drain_ff;
   logic [CntW-1:0] drain_in;
   logic [1:0]      tail_count_ff;
   logic [1:0]      tail_count_in;
   result_type [2:0] tail_ff;
   result_type [2:0] tail_in;

   logic            push_blank;
   logic            drain_blanks;
   logic [1:0]      step_count;
   result_type [2:0] step_tail;

   logic            req_beat;
   logic            rsp_beat;
   logic            list_free;
   logic            advance;

   dnp_step #(
      .MAX_PENDING_BLANKS(MAX_PENDING_BLANKS)
   ) u_step (
      .in_byte     (in_byte_ff),
      .in_last     (in_last_ff),
      .cur_state   (state_ff),
      .cur_pending (pending_ff),
      .nxt_state   (state_in),
      .nxt_pending (pending_in),
      .push_blank  (push_blank),
      .drain_blanks(drain_blanks),
      .tail_count  (step_count),
      .tail        (step_tail)
   );

   assign rsp_tvalid = (drain_ff != '0) || (tail_count_ff != 2'd0);
   assign rsp_tlast  = (drain_ff == '0) && (tail_count_ff == 2'd1);
   assign rsp_tdata  = (drain_ff != '0) ? held_ff[0] : tail_ff[0].data;
   assign rsp_tuser  = (drain_ff != '0) ? KIND_KEY : tail_ff[0].kind;

   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign list_free  = !rsp_tvalid || (rsp_tready && rsp_tlast);
   assign advance    = in_valid_ff && list_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      drain_in      = drain_ff;
      tail_count_in = tail_count_ff;
      tail_in       = tail_ff;
      if (advance) begin
         drain_in      = drain_blanks ? pending_ff : '0;
         tail_count_in = step_count;
         tail_in       = step_tail;
      end else if (rsp_beat) begin
         if (drain_ff != '0) begin
            drain_in = drain_ff - 1'b1;
         end else begin
            tail_count_in = tail_count_ff - 2'd1;
            tail_in       = {result_type'('0), tail_ff[2:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= PARSE_RESET;
         pending_ff    <= '0;
         drain_ff      <= '0;
         tail_count_ff <= 2'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         drain_ff      <= drain_in;
         tail_count_ff <= tail_count_in;
         if (advance) begin
            state_ff   <= state_in;
            pending_ff <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      tail_ff <= tail_in;
   end

   // Held key blanks: written at the fill position, emptied from the front as they drain.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PENDING_BLANKS; i++) begin
         if (advance && push_blank && (CntW'(i) == pending_ff)) begin
            held_ff[i] <= in_byte_ff;
         end else if (rsp_beat && (drain_ff != '0) && (i < MAX_PENDING_BLANKS - 1)) begin
            held_ff[i] <= held_ff[(i + 1) % MAX_PENDING_BLANKS];
         end
      end
   end

endmodule

`default_nettype wire
